// ===== hw/rtl/pstb_pkg.sv =====
// package for the periodic soft timer bank: sizes, operation codes,
// controller states and the command/status bundles between controller and datapath
// no dependencies
`default_nettype none

package pstb_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int TIMER_AW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SWEEP_CW   = $clog2(NUM_TIMERS + 1);
    localparam int MASK_PAD_W = (NUM_TIMERS > 8) ? NUM_TIMERS : 8;

    localparam int IDX_W    = 3;
    localparam int PERIOD_W = 16;
    localparam int EVT_W    = 8;
    localparam int MASK_W   = 8;
    localparam int MODE_W   = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_ACK   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_SWEEP,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic load;    // capture request fields
        logic rd_idx;  // read the addressed timer entry
        logic exec;    // apply start/stop/ack, latch before count and status
        logic sweep;   // issue next tick sweep read
        logic res_ld;  // load the output register
    } pstb_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic sweep_done;
    } pstb_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pstb_ctrl.sv =====
// controller state machine for the periodic soft timer bank
// depends on pstb_pkg; drives pstb_datapath through pstb_cmd_t
`default_nettype none

module pstb_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire pstb_pkg::pstb_sts_t sts,
    output pstb_pkg::pstb_cmd_t     cmd
);
    import pstb_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_idx = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.is_tick ? ST_SWEEP : ST_RESULT;
            end
            ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready) begin
                    cmd.res_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.res_ld) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pstb_datapath.sv =====
// datapath for the periodic soft timer bank: timer entry memories, active and
// nonzero flags, tick sweep pipeline and output register; depends on pstb_pkg
`default_nettype none

module pstb_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pstb_pkg::pstb_cmd_t           cmd,
    output pstb_pkg::pstb_sts_t                sts,
    input  wire logic [pstb_pkg::MODE_W-1:0]   s_tuser,
    input  wire logic [pstb_pkg::S_DATA_W-1:0] s_tdata,
    output logic      [pstb_pkg::M_DATA_W-1:0] m_tdata
);
    import pstb_pkg::*;

    // timer entry stores
    logic [PERIOD_W-1:0] tick_mem [NUM_TIMERS];
    logic [PERIOD_W-1:0] per_mem  [NUM_TIMERS];
    logic [EVT_W-1:0]    evt_mem  [NUM_TIMERS];

    logic [NUM_TIMERS-1:0] active_reg;
    logic [NUM_TIMERS-1:0] nz_reg;

    // captured request
    mode_t               mode_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [PERIOD_W-1:0] period_reg;

    // registered read port
    logic [PERIOD_W-1:0] rd_tick_reg;
    logic [PERIOD_W-1:0] rd_per_reg;
    logic [EVT_W-1:0]    rd_evt_reg;
    logic [TIMER_AW-1:0] rd_addr_reg;
    logic                rd_vld_reg;
    logic                rd_vld_next;

    logic [SWEEP_CW-1:0] cnt_reg;

    logic [EVT_W-1:0] before_reg;
    logic             status_reg;

    logic [EVT_W-1:0]  out_evt_reg;
    logic [MASK_W-1:0] out_mask_reg;
    logic              out_status_reg;

    logic [TIMER_AW-1:0] idx_addr;
    logic                idx_valid;
    logic                live;
    logic                rd_en;
    logic [TIMER_AW-1:0] rd_addr;

    logic [PERIOD_W:0]   tick_inc;
    logic                wr_tick;
    logic                wr_per;
    logic                wr_evt;
    logic [TIMER_AW-1:0] wr_addr;
    logic [PERIOD_W-1:0] wr_tick_data;
    logic [EVT_W-1:0]    wr_evt_data;
    logic                set_active;
    logic                clr_active;

    logic [MASK_PAD_W-1:0] pend_wide;

    assign idx_addr  = TIMER_AW'(idx_reg);
    assign idx_valid = (32'(idx_reg) < NUM_TIMERS);
    assign live      = idx_valid && active_reg[idx_addr];

    assign sts.is_tick    = (mode_reg == MODE_TICK);
    assign sts.sweep_done = (cnt_reg == SWEEP_CW'(NUM_TIMERS));

    assign rd_vld_next = cmd.sweep && !sts.sweep_done;
    assign rd_en       = cmd.rd_idx || rd_vld_next;
    assign rd_addr     = cmd.sweep ? cnt_reg[TIMER_AW-1:0] : idx_addr;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= mode_t'(s_tuser);
            idx_reg    <= s_tdata[IDX_W-1:0];
            period_reg <= s_tdata[IDX_W +: PERIOD_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_vld_next;
            if (cmd.load) begin
                cnt_reg <= '0;
            end else if (rd_vld_next) begin
                cnt_reg <= cnt_reg + SWEEP_CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_tick_reg <= tick_mem[rd_addr];
            rd_per_reg  <= per_mem[rd_addr];
            rd_evt_reg  <= evt_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    assign tick_inc = {1'b0, rd_tick_reg} + (PERIOD_W + 1)'(1);

    // sweep write-back and request writes never overlap
    always_comb begin
        wr_tick      = 1'b0;
        wr_per       = 1'b0;
        wr_evt       = 1'b0;
        wr_addr      = idx_addr;
        wr_tick_data = '0;
        wr_evt_data  = '0;
        set_active   = 1'b0;
        clr_active   = 1'b0;
        if (rd_vld_reg) begin
            wr_addr = rd_addr_reg;
            if (active_reg[rd_addr_reg]) begin
                wr_tick = 1'b1;
                wr_evt  = 1'b1;
                if (tick_inc >= {1'b0, rd_per_reg}) begin
                    wr_tick_data = '0;
                    wr_evt_data  = rd_evt_reg + EVT_W'(1);
                end else begin
                    wr_tick_data = tick_inc[PERIOD_W-1:0];
                    wr_evt_data  = rd_evt_reg;
                end
            end
        end else if (cmd.exec) begin
            case (mode_reg)
                MODE_START: begin
                    if (idx_valid) begin
                        wr_tick    = 1'b1;
                        wr_per     = 1'b1;
                        wr_evt     = 1'b1;
                        set_active = 1'b1;
                    end
                end
                MODE_STOP: begin
                    clr_active = live;
                end
                MODE_ACK: begin
                    wr_evt = live;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_tick) begin
            tick_mem[wr_addr] <= wr_tick_data;
        end
        if (wr_per) begin
            per_mem[wr_addr] <= period_reg;
        end
        if (wr_evt) begin
            evt_mem[wr_addr] <= wr_evt_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            nz_reg     <= '0;
        end else begin
            if (set_active) begin
                active_reg[wr_addr] <= 1'b1;
            end
            if (clr_active) begin
                active_reg[wr_addr] <= 1'b0;
            end
            if (wr_evt) begin
                nz_reg[wr_addr] <= (wr_evt_data != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            before_reg <= live ? rd_evt_reg : '0;
            status_reg <= ((mode_reg == MODE_STOP) || (mode_reg == MODE_ACK)) && !live;
        end
    end

    // timers past the eighth do not show in the mask
    assign pend_wide = MASK_PAD_W'(active_reg & nz_reg);

    always_ff @(posedge aclk) begin
        if (cmd.res_ld) begin
            out_evt_reg    <= before_reg;
            out_mask_reg   <= pend_wide[MASK_W-1:0];
            out_status_reg <= status_reg;
        end
    end

    assign m_tdata = {(M_DATA_W - EVT_W - MASK_W - 1)'(0), out_status_reg,
                      out_mask_reg, out_evt_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/periodic_soft_timer_bank.sv =====
// top level of the periodic soft timer bank: controller plus datapath
// depends on pstb_pkg, pstb_ctrl, pstb_datapath
//
// channel  | dir | ports                      | contents
// ---------+-----+----------------------------+---------------------------------
// request  | in  | s_tvalid s_tready s_tuser  | s_tuser: mode
//          |     | s_tdata                    | s_tdata: timer_index, period
// result   | out | m_tvalid m_tready m_tdata  | m_tdata: event_count,
//          |     |                            |   pending_mask, status
//
// start, stop and acknowledge pass through the read, execute and result states before
// m_tvalid rises; a tick also runs a sweep between execute and result that visits
// one timer entry per cycle through the single read port and write port of the memories.
// one request is in flight at a time; a new one is taken while the last result
// still waits in the output register. aresetn clears the active flags and the
// handshake state; stored periods and counts are left as they are.
`default_nettype none

module periodic_soft_timer_bank (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [pstb_pkg::MODE_W-1:0]   s_tuser,   // [1:0] mode
    input  wire logic [pstb_pkg::S_DATA_W-1:0] s_tdata,   // [2:0] timer_index,
                                                          // [18:3] period
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [pstb_pkg::M_DATA_W-1:0] m_tdata    // [7:0] event_count,
                                                          // [15:8] pending_mask,
                                                          // [16] status
);
    import pstb_pkg::*;

    pstb_cmd_t cmd;
    pstb_sts_t sts;

    pstb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pstb_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/pstb_checker.sv =====
// port-level checks for the periodic soft timer bank, bound to the top level
// depends on pstb_pkg and periodic_soft_timer_bank
`default_nettype none

module pstb_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [pstb_pkg::MODE_W-1:0]   s_tuser,
    input wire logic [pstb_pkg::S_DATA_W-1:0] s_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [pstb_pkg::M_DATA_W-1:0] m_tdata
);
    import pstb_pkg::*;

    logic unused_in;
    assign unused_in = ^{s_tuser, s_tdata};

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in flight
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in progress");

    // no result can appear right after a request is taken
    a_no_early_res: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // a flagged operation addressed an inactive timer, so its count reads zero
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[EVT_W + MASK_W] |-> m_tdata[EVT_W-1:0] == '0)
        else $error("flagged result with nonzero event count");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_DATA_W-1:EVT_W + MASK_W + 1] == '0)
        else $error("result padding bits not zero");

endmodule

bind periodic_soft_timer_bank pstb_checker u_pstb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== dv/tb_periodic_soft_timer_bank.sv =====
// testbench for periodic_soft_timer_bank: directed and random tick, start, stop and
// acknowledge requests checked against an in-bench model of the timer bank
// depends on pstb_pkg and the periodic_soft_timer_bank rtl
`timescale 1ns / 1ps

module tb_periodic_soft_timer_bank;
    import pstb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 4 + NUM_TIMERS + 8;

    typedef struct {
        mode_t       mode;
        logic [2:0]  idx;
        logic [15:0] period;
    } timer_req_t;

    typedef struct {
        logic [7:0] evt;
        logic [7:0] mask;
        logic       status;
    } timer_res_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [MODE_W-1:0]   s_tuser;    // [1:0] mode
    logic [S_DATA_W-1:0] s_tdata;    // [2:0] timer_index, [18:3] period
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;    // [7:0] event_count, [15:8] pending_mask, [16] status

    // model state of the bank
    bit [15:0] tick_cnt [NUM_TIMERS];
    bit [15:0] period_cfg [NUM_TIMERS];
    bit [7:0]  evt_cnt [NUM_TIMERS];
    bit        timer_on [NUM_TIMERS];

    timer_req_t req_q[$];
    timer_res_t result_q[$];
    timer_req_t cur_req;
    timer_res_t want_res;
    bit         offering;
    int         sent_cnt;
    int         err_cnt;
    int         cycle_cnt;
    int         hold_left;
    bit         hold_done;
    bit         calm;

    periodic_soft_timer_bank u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // both sides stop idling for a while in the middle of the run
    assign calm = (sent_cnt >= 450) && (sent_cnt < 600);

    function automatic timer_res_t timer_bank_apply(timer_req_t r);
        timer_res_t o;
        bit         live;
        bit [16:0]  nxt;
        live     = timer_on[r.idx];
        o.evt    = live ? evt_cnt[r.idx] : 8'd0;
        o.status = 1'b0;
        o.mask   = '0;
        case (r.mode)
            MODE_TICK: begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (timer_on[i]) begin
                        nxt = {1'b0, tick_cnt[i]} + 17'd1;
                        if (nxt >= {1'b0, period_cfg[i]}) begin
                            tick_cnt[i] = '0;
                            evt_cnt[i]  = evt_cnt[i] + 8'd1;
                        end else begin
                            tick_cnt[i] = nxt[15:0];
                        end
                    end
                end
            end
            MODE_START: begin
                tick_cnt[r.idx]   = '0;
                evt_cnt[r.idx]    = '0;
                period_cfg[r.idx] = r.period;
                timer_on[r.idx]   = 1'b1;
            end
            MODE_STOP: begin
                if (live) timer_on[r.idx] = 1'b0;
                else o.status = 1'b1;
            end
            default: begin
                if (live) evt_cnt[r.idx] = '0;
                else o.status = 1'b1;
            end
        endcase
        for (int i = 0; i < NUM_TIMERS && i < 8; i++) begin
            o.mask[i] = timer_on[i] && (evt_cnt[i] != 8'd0);
        end
        return o;
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                result_q.push_back(timer_bank_apply(cur_req));
                sent_cnt++;
                offering = 1'b0;
            end else begin
                offering = s_tvalid;
            end
            if (!offering && req_q.size() != 0 && (calm || $urandom_range(0, 99) >= 38)) begin
                cur_req = req_q.pop_front();
                s_tuser <= cur_req.mode;
                s_tdata <= {5'b0, cur_req.period, cur_req.idx};
                offering = 1'b1;
            end
            s_tvalid <= offering;
        end
    end

    // receiver ready, with one long hold-off so the block backs up into the sender
    always @(posedge aclk) begin
        if (!hold_done && sent_cnt >= 200) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 38);
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                $error("result with nothing expected: m_tdata=%h", m_tdata);
                err_cnt++;
            end else begin
                want_res = result_q.pop_front();
                if (m_tdata[7:0] !== want_res.evt) begin
                    $error("event_count: expected %0d, got %0d", want_res.evt, m_tdata[7:0]);
                    err_cnt++;
                end
                if (m_tdata[15:8] !== want_res.mask) begin
                    $error("pending_mask: expected %b, got %b", want_res.mask, m_tdata[15:8]);
                    err_cnt++;
                end
                if (m_tdata[16] !== want_res.status) begin
                    $error("status: expected %0d, got %0d", want_res.status, m_tdata[16]);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_periodic_soft_timer_bank: done, errors");
            $finish;
        end
    end

    task automatic push_req(mode_t mode, int idx, int period);
        timer_req_t r;
        r.mode   = mode;
        r.idx    = idx[2:0];
        r.period = period[15:0];
        req_q.push_back(r);
    endtask

    // sampled at the falling edge so every clocked process has settled
    task automatic wait_drained();
        @(negedge aclk);
        while (req_q.size() != 0 || s_tvalid || result_q.size() != 0) @(negedge aclk);
    endtask

    // mostly short periods so events fire, now and then a full-range one
    function automatic int pick_period();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return $urandom_range(0, 6);
        if (sel < 90) return $urandom_range(0, 40);
        return $urandom_range(0, 65535);
    endfunction

    initial begin
        int sel;
        int other;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = '0;
        s_tdata  = '0;
        m_tready = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: inactive targets, extreme periods, restart, double stop
        push_req(MODE_ACK, 0, 0);
        push_req(MODE_STOP, 7, 0);
        push_req(MODE_TICK, 5, 65535);
        push_req(MODE_START, 0, 0);
        push_req(MODE_START, 7, 65535);
        push_req(MODE_START, 3, 1);
        push_req(MODE_START, 5, 2);
        repeat (3) push_req(MODE_TICK, 0, 0);
        push_req(MODE_ACK, 0, 0);
        push_req(MODE_ACK, 0, 0);
        push_req(MODE_START, 3, 4);
        push_req(MODE_STOP, 5, 0);
        push_req(MODE_STOP, 5, 0);
        push_req(MODE_ACK, 5, 0);
        push_req(MODE_ACK, 7, 0);
        push_req(MODE_TICK, 7, 16'hAAAA);
        push_req(MODE_START, 0, 16'h5555);
        push_req(MODE_STOP, 7, 0);
        push_req(MODE_STOP, 0, 0);
        push_req(MODE_STOP, 3, 0);
        wait_drained();

        // long tick run so two every-tick timers wrap their 8-bit event count
        push_req(MODE_START, 2, 0);
        push_req(MODE_START, 6, 1);
        for (int k = 0; k < 300; k++) begin
            if (k % 8 != 7) begin
                push_req(MODE_TICK, $urandom_range(0, 7), $urandom_range(0, 65535));
            end else begin
                do other = $urandom_range(0, 7); while (other == 2 || other == 6);
                push_req(mode_t'($urandom_range(1, 3)), other, pick_period());
            end
        end
        push_req(MODE_ACK, 2, 0);
        push_req(MODE_ACK, 6, 0);
        wait_drained();

        for (int k = 0; k < 480; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) push_req(MODE_TICK, $urandom_range(0, 7), $urandom_range(0, 65535));
            else if (sel < 65) push_req(MODE_START, $urandom_range(0, 7), pick_period());
            else if (sel < 77) push_req(MODE_STOP, $urandom_range(0, 7), pick_period());
            else push_req(MODE_ACK, $urandom_range(0, 7), pick_period());
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_cnt == 0 && result_q.size() == 0) begin
            $display("tb_periodic_soft_timer_bank: done, clean");
        end else begin
            $display("tb_periodic_soft_timer_bank: done, errors");
        end
        $finish;
    end

endmodule
